### rtl/core/dssd_pkg.sv
// Shared types and constants for the dual stack set difference block.
package dssd_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    ACT_PUSH_A = 3'd0,
    ACT_PUSH_B = 3'd1,
    ACT_POP_A  = 3'd2,
    ACT_POP_B  = 3'd3,
    ACT_DIFF   = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_ELEM        = 3'd1,
    ST_POP_EMPTY   = 3'd2,
    ST_PUSH_FULL   = 3'd3,
    ST_STACK_EMPTY = 3'd4,
    ST_NONE_LEFT   = 3'd5
  } st_e;

  typedef struct packed {
    word_t value;
    st_e   status;
    logic  last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec_simple;
    logic start_walk;
    logic clr_j;
    logic lat_e;
    logic j_inc;
    logic keep;
    logic i_inc;
    logic finish;
    logic i_dec;
    logic push_none;
    logic push_elem;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic diff_ok;
    logic q_room;
    logic match;
    logic j_last;
    logic i_last;
    logic kept_zero;
    logic i_zero;
  } stat_t;

endpackage

### rtl/core/dssd_outq.sv
// Two-entry result queue that decouples the datapath from the output stream.
module dssd_outq import dssd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic room_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  res_t       ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q != 2'd2);
  assign data_o  = ent_q[rd_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/core/dssd_ctrl.sv
// Controller state machine: sequences simple actions and the difference walk.
module dssd_ctrl import dssd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_A_RD  = 8'b0000_0010,
    S_A_LAT = 8'b0000_0100,
    S_B_RD  = 8'b0000_1000,
    S_B_CHK = 8'b0001_0000,
    S_FIN   = 8'b0010_0000,
    S_E_RD  = 8'b0100_0000,
    S_E_OUT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = stat_i.q_room;
        if (s_valid_i && stat_i.q_room) begin
          if (stat_i.diff_ok) begin
            cmd_o.start_walk = 1'b1;
            state_d          = S_A_RD;
          end else begin
            cmd_o.exec_simple = 1'b1;
          end
        end
      end
      S_A_RD: begin
        cmd_o.clr_j = 1'b1;
        state_d     = S_A_LAT;
      end
      S_A_LAT: begin
        cmd_o.lat_e = 1'b1;
        state_d     = S_B_RD;
      end
      S_B_RD: begin
        state_d = S_B_CHK;
      end
      S_B_CHK: begin
        if (!stat_i.match && !stat_i.j_last) begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_B_RD;
        end else begin
          cmd_o.keep = !stat_i.match;
          if (stat_i.i_last) begin
            state_d = S_FIN;
          end else begin
            cmd_o.i_inc = 1'b1;
            state_d     = S_A_RD;
          end
        end
      end
      S_FIN: begin
        if (!stat_i.kept_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = S_E_RD;
        end else if (stat_i.q_room) begin
          cmd_o.finish    = 1'b1;
          cmd_o.push_none = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_E_RD: begin
        state_d = S_E_OUT;
      end
      S_E_OUT: begin
        if (stat_i.q_room) begin
          cmd_o.push_elem = 1'b1;
          if (stat_i.i_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.i_dec = 1'b1;
            state_d     = S_E_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/dssd_dpath.sv
// Datapath: both stack memories, counters, walk indexes and the compare.
module dssd_dpath import dssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  s_act_i,
  input  word_t       s_value_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output res_t        m_data_o
);

  word_t mem_a [DEPTH];
  word_t mem_b [DEPTH];
  word_t rdata_a_q, rdata_b_q;
  word_t e_q;

  logic [CNT_W-1:0] fc_q, fc_d, sc_q, sc_d, kept_q, kept_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;

  act_e             act;
  st_e              simple_st;
  logic             a_push, b_push, a_we;
  logic [IDX_W-1:0] a_waddr;
  word_t            a_wdata;
  logic             q_push, q_room;
  res_t             q_data;

  assign act = act_e'(s_act_i);

  always_comb begin
    fc_d      = fc_q;
    sc_d      = sc_q;
    simple_st = ST_DONE;
    a_push    = 1'b0;
    b_push    = 1'b0;
    if (cmd_i.exec_simple) begin
      case (act)
        ACT_PUSH_A: begin
          if (fc_q == CNT_W'(DEPTH)) begin
            simple_st = ST_PUSH_FULL;
          end else begin
            a_push = 1'b1;
            fc_d   = fc_q + CNT_W'(1);
          end
        end
        ACT_PUSH_B: begin
          if (sc_q == CNT_W'(DEPTH)) begin
            simple_st = ST_PUSH_FULL;
          end else begin
            b_push = 1'b1;
            sc_d   = sc_q + CNT_W'(1);
          end
        end
        ACT_POP_A: begin
          if (fc_q == '0) begin
            simple_st = ST_POP_EMPTY;
          end else begin
            fc_d = fc_q - CNT_W'(1);
          end
        end
        ACT_POP_B: begin
          if (sc_q == '0) begin
            simple_st = ST_POP_EMPTY;
          end else begin
            sc_d = sc_q - CNT_W'(1);
          end
        end
        ACT_DIFF: begin
          // Reaches here only when one of the stacks is empty.
          simple_st = ST_STACK_EMPTY;
        end
        default: begin
          simple_st = ST_DONE;
        end
      endcase
    end
    if (cmd_i.finish) begin
      fc_d = kept_q;
    end
  end

  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    kept_d = kept_q;
    if (cmd_i.start_walk) begin
      i_d    = '0;
      kept_d = '0;
    end
    if (cmd_i.i_inc) begin
      i_d = i_q + IDX_W'(1);
    end
    if (cmd_i.finish) begin
      i_d = IDX_W'(kept_q - CNT_W'(1));
    end
    if (cmd_i.i_dec) begin
      i_d = i_q - IDX_W'(1);
    end
    if (cmd_i.keep) begin
      kept_d = kept_q + CNT_W'(1);
    end
    if (cmd_i.clr_j) begin
      j_d = '0;
    end
    if (cmd_i.j_inc) begin
      j_d = j_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q   <= '0;
      sc_q   <= '0;
      kept_q <= '0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      fc_q   <= fc_d;
      sc_q   <= sc_d;
      kept_q <= kept_d;
      i_q    <= i_d;
      j_q    <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_e) begin
      e_q <= rdata_a_q;
    end
  end

  // Survivors are written back at the kept index, which never passes the read index.
  assign a_we    = a_push || cmd_i.keep;
  assign a_waddr = cmd_i.keep ? kept_q[IDX_W-1:0] : fc_q[IDX_W-1:0];
  assign a_wdata = cmd_i.keep ? e_q : s_value_i;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_a[a_waddr] <= a_wdata;
    end
    rdata_a_q <= mem_a[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (b_push) begin
      mem_b[sc_q[IDX_W-1:0]] <= s_value_i;
    end
    rdata_b_q <= mem_b[j_q];
  end

  assign stat_o.diff_ok   = (act == ACT_DIFF) && (fc_q != '0) && (sc_q != '0);
  assign stat_o.q_room    = q_room;
  assign stat_o.match     = (rdata_b_q == e_q);
  assign stat_o.j_last    = ((CNT_W'(j_q) + CNT_W'(1)) == sc_q);
  assign stat_o.i_last    = ((CNT_W'(i_q) + CNT_W'(1)) == fc_q);
  assign stat_o.kept_zero = (kept_q == '0);
  assign stat_o.i_zero    = (i_q == '0);

  always_comb begin
    q_push = cmd_i.exec_simple || cmd_i.push_none || cmd_i.push_elem;
    if (cmd_i.push_elem) begin
      q_data = '{value: rdata_a_q, status: ST_ELEM, last: (i_q == '0)};
    end else if (cmd_i.push_none) begin
      q_data = '{value: '0, status: ST_NONE_LEFT, last: 1'b1};
    end else begin
      q_data = '{value: '0, status: simple_st, last: 1'b1};
    end
  end

  dssd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_data),
    .room_o  (q_room),
    .valid_o (m_valid_o),
    .ready_i (m_ready_i),
    .data_o  (m_data_o)
  );

endmodule

### rtl/core/dual_stack_set_difference.sv
// Top level of the dual stack set difference block: controller, datapath, checks.
//
//   Channel   Direction  tdata            tuser         tlast
//   s_axis    in         value [31:0]     action [2:0]  -
//   m_axis    out        value_res [31:0] status [2:0]  last of the run
//
// Push, pop, an undefined action and a difference with an empty stack take one
// cycle per beat; the input is taken while the controller is idle and the
// two-entry result queue has room. A difference walk reads the F elements of
// the first stack, makes at most S compares each against the second stack,
// writes back the K survivors and sends them out top first, using the single
// read port of each stack memory. Reset clears both counts; the stack memories
// are not cleared. A stalled output holds the queue and, once it is full, the walk.
module dual_stack_set_difference import dssd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input beats.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic signed [31:0] s_axis_tdata,  // [31:0] value
  input  logic [2:0]   s_axis_tuser,        // [2:0] action
  // Result beats.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic signed [31:0] m_axis_tdata,  // [31:0] value_res
  output logic [2:0]   m_axis_tuser,        // [2:0] status
  output logic         m_axis_tlast
);

  cmd_t  cmd;
  stat_t stat;
  res_t  res;

  // The controller decides what happens each cycle; the datapath only obeys.
  dssd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // The datapath holds both stacks and the result queue.
  dssd_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_act_i   (s_axis_tuser),
    .s_value_i (s_axis_tdata),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (res)
  );

  assign m_axis_tdata = res.value;
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

  // A result is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec_simple || cmd.push_none || cmd.push_elem) |-> stat.q_room)
    else $error("result pushed into a full queue");

  // A walk only starts when both stacks hold something.
  a_walk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_walk |-> stat.diff_ok)
    else $error("difference walk started with an empty stack");

  // Once a walk starts, no further input beat is taken on the next cycle.
  a_walk_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_walk |=> !s_axis_tready)
    else $error("input taken during a difference walk");

  // Every beat that is not a surviving element closes its run.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_ELEM)) |-> m_axis_tlast)
    else $error("non-element result without last");

endmodule

### dv/dssd_result_checker.sv
// Checker for the dual stack set difference block: predicts every result beat and compares.
`timescale 1ns / 1ps

module dssd_result_checker import dssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  word_t       s_axis_tdata_i,
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  word_t       m_axis_tdata_i,
  input  logic [2:0]  m_axis_tuser_i,
  input  logic        m_axis_tlast_i,
  output int          err_cnt_o,
  output int          pending_o
);

  // Shadow copy of both stacks; entry 0 is the bottom.
  word_t first_mem [DEPTH];
  word_t second_mem [DEPTH];
  int    first_cnt;
  int    second_cnt;

  // Result beats still owed by the block, oldest first.
  res_t  owed_res_q [$];

  function automatic res_t make_res(input word_t val, input st_e st, input logic lst);
    res_t r;
    r.value  = val;
    r.status = st;
    r.last   = lst;
    return r;
  endfunction

  // Applies one accepted input beat to the shadow stacks and queues its results.
  function automatic void apply_action(input logic [2:0] act, input word_t val);
    word_t survivors [$];
    bit    hit;
    st_e   st;
    st = ST_DONE;
    case (act)
      ACT_PUSH_A: begin
        if (first_cnt >= DEPTH) st = ST_PUSH_FULL;
        else begin
          first_mem[first_cnt] = val;
          first_cnt++;
        end
      end
      ACT_PUSH_B: begin
        if (second_cnt >= DEPTH) st = ST_PUSH_FULL;
        else begin
          second_mem[second_cnt] = val;
          second_cnt++;
        end
      end
      ACT_POP_A: begin
        if (first_cnt == 0) st = ST_POP_EMPTY;
        else first_cnt--;
      end
      ACT_POP_B: begin
        if (second_cnt == 0) st = ST_POP_EMPTY;
        else second_cnt--;
      end
      ACT_DIFF: begin
        if (first_cnt == 0 || second_cnt == 0) st = ST_STACK_EMPTY;
        else begin
          for (int i = 0; i < first_cnt; i++) begin
            hit = 1'b0;
            for (int j = 0; j < second_cnt; j++)
              if (second_mem[j] == first_mem[i]) hit = 1'b1;
            if (!hit) survivors.push_back(first_mem[i]);
          end
          first_cnt = survivors.size();
          foreach (survivors[i]) first_mem[i] = survivors[i];
          if (first_cnt == 0) st = ST_NONE_LEFT;
          else begin
            // Survivors leave top first; the bottom one closes the run.
            for (int i = first_cnt - 1; i >= 0; i--)
              owed_res_q.push_back(make_res(survivors[i], ST_ELEM, i == 0));
            return;
          end
        end
      end
      default: st = ST_DONE;
    endcase
    owed_res_q.push_back(make_res('0, st, 1'b1));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      first_cnt = 0;
      second_cnt = 0;
      owed_res_q.delete();
    end else begin
      // A result can never come from the input taken at the same edge, so the
      // output side is checked first.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (owed_res_q.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 10)
            $display("%0t: unexpected result beat value %0d status %0d last %0b",
                     $time, m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
        end else begin
          want = owed_res_q.pop_front();
          if (want.value !== m_axis_tdata_i || want.status !== m_axis_tuser_i ||
              want.last !== m_axis_tlast_i) begin
            err_cnt_o++;
            if (err_cnt_o <= 10)
              $display({"%0t: result mismatch, expected value %0d status %0d last %0b,",
                        " got value %0d status %0d last %0b"},
                       $time, want.value, want.status, want.last,
                       m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        apply_action(s_axis_tuser_i, s_axis_tdata_i);
    end
    pending_o = owed_res_q.size();
  end

endmodule

### dv/tb_dual_stack_set_difference.sv
// Testbench top for the dual stack set difference block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_dual_stack_set_difference import dssd_pkg::*;;

  // Action codes the block leaves undefined; they must be answered with done.
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;
  localparam logic [2:0] ACT_MAX   = ACT_RSVD7;

  localparam int N_ITEMS   = 270;
  // From this beat on both sides run without idling.
  localparam int QUIET_AT  = 225;
  // Watchdog bound on the length of the whole run.
  localparam int LIMIT     = 1_500_000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  word_t       s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = ACT_PUSH_A;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  word_t       m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          err_cnt;
  int          pending;
  int          sent = 0;
  int          cycles = 0;
  int          rx_stall_left = 0;
  bit          quiet = 1'b0;

  // A small pool of values shared by both stacks, so that the difference
  // actually finds common values.
  word_t       pool [8];

  dual_stack_set_difference u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  dssd_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_dual_stack_set_difference: errors");
      $finish;
    end
  end

  // Result side: the sink stalls in random bursts, and is
  // always ready once the run has gone quiet.
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      rx_stall_left <= $urandom_range(1, 18) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Sends one input beat, sometimes after an idle burst, and returns at the
  // edge where the block takes it. Valid stays high into the next beat, so it
  // is only lowered when an idle burst follows.
  task automatic send_beat(input logic [2:0] act, input word_t val);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (sent >= QUIET_AT) quiet = 1'b1;
  endtask

  task automatic refresh_pool();
    foreach (pool[k]) begin
      case ($urandom_range(0, 5))
        0: pool[k] = '0;
        1: pool[k] = -1;
        2: pool[k] = 32'sh8000_0000;
        3: pool[k] = 32'sh7fff_ffff;
        default: pool[k] = $urandom();
      endcase
    end
  endtask

  function automatic word_t pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return pool[$urandom_range(0, 7)];
  endfunction

  // Pushes past the capacity of one stack so that the last pushes overflow,
  // then runs a difference against whatever the other stack holds. Fully
  // random values make a full run of survivors likely.
  task automatic fill_stack(input logic [2:0] push_act);
    int  n;
    bit  from_pool;
    n = DEPTH + $urandom_range(1, 2);
    from_pool = 1'($urandom_range(0, 1));
    repeat (n) send_beat(push_act, from_pool ? pick_value() : word_t'($urandom()));
    if (push_act == ACT_PUSH_A) send_beat(ACT_PUSH_B, pick_value());
    send_beat(ACT_DIFF, $urandom());
  endtask

  initial begin : stim
    int         na;
    int         nb;
    logic [2:0] act;
    refresh_pool();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-stack errors, the undefined actions, extreme values,
    // a difference with duplicate survivors and one that removes everything.
    send_beat(ACT_POP_A, 32'sh7fff_ffff);
    send_beat(ACT_POP_B, 32'sh8000_0000);
    send_beat(ACT_DIFF, '0);
    send_beat(ACT_RSVD5, -1);
    send_beat(ACT_RSVD6, '0);
    send_beat(ACT_RSVD7, -1);
    send_beat(ACT_PUSH_A, 32'sh8000_0000);
    send_beat(ACT_DIFF, -1);
    send_beat(ACT_PUSH_A, 32'sh7fff_ffff);
    send_beat(ACT_PUSH_A, 32'sh8000_0000);
    send_beat(ACT_PUSH_B, 32'sh7fff_ffff);
    send_beat(ACT_DIFF, '0);
    send_beat(ACT_PUSH_B, 32'sh8000_0000);
    send_beat(ACT_DIFF, '0);
    send_beat(ACT_POP_A, '0);
    send_beat(ACT_POP_B, '0);
    send_beat(ACT_POP_B, '0);
    send_beat(ACT_POP_B, '0);
    send_beat(ACT_PUSH_A, '0);
    send_beat(ACT_PUSH_A, -1);
    send_beat(ACT_POP_A, -1);
    send_beat(ACT_POP_A, '0);

    // Random part: mostly push sequences that end in a difference, plus
    // overflow fills, drains and noise with every action code.
    while (sent < N_ITEMS) begin
      case ($urandom_range(0, 19))
        11, 12: fill_stack(ACT_PUSH_A);
        13: fill_stack(ACT_PUSH_B);
        14, 15: begin
          repeat ($urandom_range(1, DEPTH + 1)) send_beat(ACT_POP_A, $urandom());
          repeat ($urandom_range(1, DEPTH + 1)) send_beat(ACT_POP_B, $urandom());
        end
        16, 17, 18, 19: begin
          repeat ($urandom_range(1, 6)) begin
            act = 3'($urandom_range(0, ACT_MAX));
            send_beat(act, $urandom());
          end
        end
        default: begin
          if ($urandom_range(0, 2) == 0) refresh_pool();
          na = $urandom_range(0, 7);
          nb = $urandom_range(0, 5);
          while (na > 0 || nb > 0) begin
            if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 1)) begin
              send_beat(ACT_PUSH_A, pick_value());
              na--;
            end else begin
              send_beat(ACT_PUSH_B, pick_value());
              nb--;
            end
            if ($urandom_range(0, 7) == 0)
              send_beat($urandom_range(0, 1) ? ACT_POP_A : ACT_POP_B, $urandom());
          end
          send_beat(ACT_DIFF, $urandom());
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;

    // One more edge lets the checker book the last beat before draining.
    @(posedge clk_i);
    wait (pending == 0);
    repeat (64) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("tb_dual_stack_set_difference: clean");
    end else begin
      $display("tb_dual_stack_set_difference: errors");
    end
    $finish;
  end

endmodule
